// ----- rtl/core/rau_pkg.sv -----
// Package for the rational arithmetic unit: widths, mode codes, state type and
// the command/status structs shared by the controller and the datapath.
// Depends on nothing.
package rau_pkg;

   localparam int WIDTH     = 16;
   localparam int PROD_W    = 2 * WIDTH + 2;       // signed product or sum of two
   localparam int MAG_W     = PROD_W - 1;          // magnitude of a product value
   localparam int CNT_W     = $clog2(MAG_W + 1);

   typedef enum logic [2:0] {
      MODE_ADD  = 3'd0,
      MODE_SUB  = 3'd1,
      MODE_MUL  = 3'd2,
      MODE_DIV  = 3'd3,
      MODE_INC  = 3'd4,
      MODE_DEC  = 3'd5,
      MODE_CMP  = 3'd6,
      MODE_NORM = 3'd7
   } mode_type;

   // Datapath phases; the operand pair is normalised first, then the result.
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD_A,
      ST_GCD_A,
      ST_DIV_A,
      ST_LOAD_B,
      ST_GCD_B,
      ST_DIV_B,
      ST_MUL1,
      ST_MUL2,
      ST_COMBINE,
      ST_LOAD_R,
      ST_GCD_R,
      ST_DIV_R,
      ST_FINISH,
      ST_HOLD
   } state_type;

   typedef enum logic [1:0] {
      SEL_A,
      SEL_B,
      SEL_R
   } sel_type;

   typedef struct packed {
      logic    capture;     // take request fields
      logic    load;        // load a fraction into the reducer
      sel_type sel;         // which fraction
      logic    gcd_step;    // one Euclid step (shift-subtract)
      logic    div_start;   // start quotient division
      logic    div_step;    // one quotient bit
      logic    div_store;   // write reduced fraction back
      logic    mul1;        // first pair of products
      logic    mul2;        // second pair of products
      logic    combine;     // form raw result
      logic    finish;      // latch output fields
   } cmd_type;

   typedef struct packed {
      logic gcd_done;
      logic div_done;
      logic is_cmp;
   } status_type;

endpackage

// ----- rtl/core/rau_ctrl.sv -----
// Controller for the rational arithmetic unit: sequences load, reduction,
// multiplication and output phases. Depends on rau_pkg.
module rau_ctrl
   import rau_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands.
   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.sel   = SEL_A;
      req_stall = 1'b1;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ST_LOAD_A;
            end
         end
         ST_LOAD_A: begin
            cmd.load = 1'b1;
            cmd.sel  = SEL_A;
            state_in = ST_GCD_A;
         end
         ST_GCD_A: begin
            cmd.sel = SEL_A;
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_A;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_A: begin
            cmd.sel = SEL_A;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_LOAD_B;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_LOAD_B: begin
            cmd.load = 1'b1;
            cmd.sel  = SEL_B;
            state_in = ST_GCD_B;
         end
         ST_GCD_B: begin
            cmd.sel = SEL_B;
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_B;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_B: begin
            cmd.sel = SEL_B;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_MUL1;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_MUL1: begin
            cmd.mul1 = 1'b1;
            state_in = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul2 = 1'b1;
            state_in = ST_COMBINE;
         end
         ST_COMBINE: begin
            cmd.combine = 1'b1;
            state_in    = status.is_cmp ? ST_FINISH : ST_LOAD_R;
         end
         ST_LOAD_R: begin
            cmd.load = 1'b1;
            cmd.sel  = SEL_R;
            state_in = ST_GCD_R;
         end
         ST_GCD_R: begin
            cmd.sel = SEL_R;
            if (status.gcd_done) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV_R;
            end else begin
               cmd.gcd_step = 1'b1;
            end
         end
         ST_DIV_R: begin
            cmd.sel = SEL_R;
            if (status.div_done) begin
               cmd.div_store = 1'b1;
               state_in      = ST_FINISH;
            end else begin
               cmd.div_step = 1'b1;
            end
         end
         ST_FINISH: begin
            cmd.finish = 1'b1;
            state_in   = ST_HOLD;
         end
         ST_HOLD: begin
            // The result waits here; a new request is taken only once back in idle.
            rsp_valid = 1'b1;
            if (!rsp_stall) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/rau_dp.sv -----
// Datapath for the rational arithmetic unit: operand registers, a binary GCD
// reducer, a restoring divider and two multipliers. Depends on rau_pkg.
module rau_dp
   import rau_pkg::*;
(
   input  logic                    clock,
   input  cmd_type                 cmd,
   output status_type              status,
   input  logic [2:0]              req_mode,
   input  logic signed [WIDTH-1:0] req_left_num,
   input  logic signed [WIDTH-1:0] req_left_den,
   input  logic signed [WIDTH-1:0] req_right_num,
   input  logic signed [WIDTH-1:0] req_right_den,
   output logic signed [WIDTH-1:0] rsp_res_num,
   output logic [WIDTH-2:0]        rsp_res_den,
   output logic                    rsp_is_less,
   output logic                    rsp_is_equal,
   output logic                    rsp_zero_den,
   output logic                    rsp_overflow
);

   mode_type mode_ff;
   // Fractions as sign plus magnitude; den is nonnegative after loading.
   logic              an_s_ff, bn_s_ff, rn_s_ff;
   logic [MAG_W-1:0]  an_ff, ad_ff, bn_ff, bd_ff, rn_ff, rd_ff;
   // Reducer: working pair for Euclid (binary form) and the common power of two.
   logic [MAG_W-1:0]  gu_ff, gv_ff;
   logic [CNT_W-1:0]  gk_ff;
   // Divider state: two dividends share one divisor.
   logic [MAG_W-1:0]  dq0_ff, dq1_ff, dr0_ff, dr1_ff, dvs_ff;
   logic [CNT_W-1:0]  dcnt_ff;
   // Products.
   logic signed [PROD_W-1:0] p0_ff, p1_ff, p2_ff;
   logic                     lt_ff, eq_ff;

   // Selected fraction for load and store.
   logic             sel_s;
   logic [MAG_W-1:0] sel_n, sel_d;
   always_comb begin
      case (cmd.sel)
         SEL_A:   begin sel_s = an_s_ff; sel_n = an_ff; sel_d = ad_ff; end
         SEL_B:   begin sel_s = bn_s_ff; sel_n = bn_ff; sel_d = bd_ff; end
         SEL_R:   begin sel_s = rn_s_ff; sel_n = rn_ff; sel_d = rd_ff; end
         default: begin sel_s = an_s_ff; sel_n = an_ff; sel_d = ad_ff; end
      endcase
   end

   // Sign fix-up on load: a negative denominator flips the numerator sign,
   // and a zero numerator takes denominator one.
   function automatic logic [MAG_W-1:0] mag_of(input logic signed [WIDTH-1:0] v);
      logic signed [MAG_W-1:0] x;
      x = MAG_W'(v);
      return (v < 0) ? MAG_W'(-x) : MAG_W'(x);
   endfunction

   // Binary GCD step.
   logic gcd_done_w;
   assign gcd_done_w = (gu_ff == '0) || (gv_ff == '0);
   logic [MAG_W-1:0] gcd_w;
   assign gcd_w = (gu_ff | gv_ff) << gk_ff;

   // Restoring divider, one quotient bit of each dividend per cycle.
   logic [MAG_W:0] t0, t1;
   assign t0 = {dr0_ff, dq0_ff[MAG_W-1]};
   assign t1 = {dr1_ff, dq1_ff[MAG_W-1]};
   logic sub0, sub1;
   assign sub0 = t0 >= {1'b0, dvs_ff};
   assign sub1 = t1 >= {1'b0, dvs_ff};

   assign status.gcd_done = gcd_done_w;
   assign status.div_done = (dcnt_ff == '0);
   assign status.is_cmp   = (mode_ff == MODE_CMP);

   // Signed views of the reduced operands.
   logic signed [WIDTH+1:0] asn, asd, bsn, bsd;
   assign asn = an_s_ff ? -$signed({1'b0, an_ff[WIDTH:0]}) : $signed({1'b0, an_ff[WIDTH:0]});
   assign asd = $signed({1'b0, ad_ff[WIDTH:0]});
   assign bsn = bn_s_ff ? -$signed({1'b0, bn_ff[WIDTH:0]}) : $signed({1'b0, bn_ff[WIDTH:0]});
   assign bsd = $signed({1'b0, bd_ff[WIDTH:0]});

   // Raw result before reduction.
   logic signed [PROD_W-1:0] raw_n, raw_d;
   always_comb begin
      case (mode_ff)
         MODE_ADD: begin raw_n = p0_ff + p1_ff;   raw_d = p2_ff; end
         MODE_SUB: begin raw_n = p0_ff - p1_ff;   raw_d = p2_ff; end
         MODE_MUL: begin raw_n = p1_ff;           raw_d = p2_ff; end
         MODE_DIV: begin raw_n = p0_ff;           raw_d = p1_ff; end
         MODE_INC: begin raw_n = PROD_W'(asn) + PROD_W'(asd); raw_d = PROD_W'(asd); end
         MODE_DEC: begin raw_n = PROD_W'(asn) - PROD_W'(asd); raw_d = PROD_W'(asd); end
         default:  begin raw_n = PROD_W'(asn);    raw_d = PROD_W'(asd); end
      endcase
   end

   // Field range check on the reduced result.
   logic signed [PROD_W-1:0] fin_n;
   assign fin_n = rn_s_ff ? -$signed({1'b0, rn_ff}) : $signed({1'b0, rn_ff});
   logic ovf_w;
   assign ovf_w = (fin_n < -(PROD_W'(1) <<< (WIDTH-1)))
               || (fin_n > ((PROD_W'(1) <<< (WIDTH-1)) - 1))
               || (rd_ff > ((MAG_W'(1) << (WIDTH-1)) - 1));

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff <= mode_type'(req_mode);
         an_s_ff <= (req_left_num < 0) ^ (req_left_den < 0);
         an_ff   <= mag_of(req_left_num);
         ad_ff   <= (req_left_num == '0) ? MAG_W'(1) : mag_of(req_left_den);
         bn_s_ff <= (req_right_num < 0) ^ (req_right_den < 0);
         bn_ff   <= mag_of(req_right_num);
         bd_ff   <= (req_right_num == '0) ? MAG_W'(1) : mag_of(req_right_den);
      end
      if (cmd.load) begin
         gu_ff <= sel_n;
         gv_ff <= sel_d;
         gk_ff <= '0;
      end
      if (cmd.gcd_step) begin
         if (!gu_ff[0] && !gv_ff[0]) begin
            gu_ff <= gu_ff >> 1;
            gv_ff <= gv_ff >> 1;
            gk_ff <= gk_ff + CNT_W'(1);
         end else if (!gu_ff[0]) begin
            gu_ff <= gu_ff >> 1;
         end else if (!gv_ff[0]) begin
            gv_ff <= gv_ff >> 1;
         end else if (gu_ff >= gv_ff) begin
            gu_ff <= (gu_ff - gv_ff) >> 1;
         end else begin
            gv_ff <= (gv_ff - gu_ff) >> 1;
         end
      end
      if (cmd.div_start) begin
         dq0_ff  <= sel_n;
         dq1_ff  <= sel_d;
         dr0_ff  <= '0;
         dr1_ff  <= '0;
         // Zero gcd only when both are zero, which loading rules out; guard anyway.
         dvs_ff  <= (gcd_w == '0) ? MAG_W'(1) : gcd_w;
         dcnt_ff <= CNT_W'(MAG_W);
      end
      if (cmd.div_step) begin
         dr0_ff  <= sub0 ? MAG_W'(t0 - {1'b0, dvs_ff}) : t0[MAG_W-1:0];
         dr1_ff  <= sub1 ? MAG_W'(t1 - {1'b0, dvs_ff}) : t1[MAG_W-1:0];
         dq0_ff  <= {dq0_ff[MAG_W-2:0], sub0};
         dq1_ff  <= {dq1_ff[MAG_W-2:0], sub1};
         dcnt_ff <= dcnt_ff - CNT_W'(1);
      end
      if (cmd.div_store) begin
         case (cmd.sel)
            SEL_A:   begin an_ff <= dq0_ff; ad_ff <= dq1_ff; end
            SEL_B:   begin bn_ff <= dq0_ff; bd_ff <= dq1_ff; end
            default: begin rn_ff <= dq0_ff; rd_ff <= dq1_ff; end
         endcase
      end
      if (cmd.mul1) begin
         p0_ff <= PROD_W'(asn * bsd);
         p1_ff <= (mode_ff == MODE_MUL) ? PROD_W'(asn * bsn) : PROD_W'(bsn * asd);
      end
      if (cmd.mul2) begin
         p2_ff <= (mode_ff == MODE_DIV) ? p1_ff : PROD_W'(asd * bsd);
         if (mode_ff == MODE_DIV) begin
            p1_ff <= PROD_W'(asd * bsn);
         end
      end
      if (cmd.combine) begin
         lt_ff <= p0_ff < p1_ff;
         eq_ff <= p0_ff == p1_ff;
         rn_s_ff <= (raw_n < 0) ^ (raw_d < 0);
         rn_ff   <= (raw_n < 0) ? MAG_W'(-raw_n) : MAG_W'(raw_n);
         rd_ff   <= (raw_n == '0) ? MAG_W'(1)
                  : ((raw_d < 0) ? MAG_W'(-raw_d) : MAG_W'(raw_d));
      end
      if (cmd.finish) begin
         if (mode_ff == MODE_CMP) begin
            rsp_res_num  <= '0;
            rsp_res_den  <= '0;
            rsp_zero_den <= 1'b0;
            rsp_overflow <= 1'b0;
            rsp_is_less  <= lt_ff;
            rsp_is_equal <= eq_ff;
         end else begin
            rsp_res_num  <= fin_n[WIDTH-1:0];
            rsp_res_den  <= rd_ff[WIDTH-2:0];
            rsp_zero_den <= (rd_ff == '0);
            rsp_overflow <= ovf_w;
            rsp_is_less  <= 1'b0;
            rsp_is_equal <= 1'b0;
         end
      end
   end

endmodule

// ----- rtl/core/rational_arithmetic_unit_core.sv -----
// Rational arithmetic unit: two signed fractions in, one reduced fraction out.
// The block is used through two valid/stall channels. A request carries a mode
// and two fractions; it is taken when req_valid is high and req_stall low.
// Each operand is put in lowest terms, the operation is performed exactly on
// products of up to 34 bits, and the result is reduced again by a binary GCD
// followed by a shift-subtract division of both parts by that GCD.
// Latency varies with the operands. Each reduction runs a load, GCD steps until
// one part is zero (one GCD step per cycle), and the 33-bit division. A compare
// request reduces only the two operands; any other request also reduces the
// result. The GCD reducer and the divider are shared by all three reductions,
// and one request is in work at a time; a new request is not taken until the
// response of the last one has left.
// The response holds in an output register with rsp_valid high until taken
// with rsp_stall low; while the receiver stalls, req_stall stays high. A new
// request is taken in the cycle after the response leaves.
// Synchronous active-high reset returns the controller to idle; no response
// is pending after reset.
// Depends on rau_pkg, rau_ctrl and rau_dp.
module rational_arithmetic_unit_core
   import rau_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [2:0]              req_mode,
   input  logic signed [WIDTH-1:0] req_left_num,
   input  logic signed [WIDTH-1:0] req_left_den,
   input  logic signed [WIDTH-1:0] req_right_num,
   input  logic signed [WIDTH-1:0] req_right_den,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WIDTH-1:0] rsp_res_num,
   output logic [WIDTH-2:0]        rsp_res_den,
   output logic                    rsp_is_less,
   output logic                    rsp_is_equal,
   output logic                    rsp_zero_den,
   output logic                    rsp_overflow
);

   cmd_type    cmd;
   status_type status;

   rau_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .status    (status),
      .cmd       (cmd)
   );

   rau_dp u_dp (
      .clock         (clock),
      .cmd           (cmd),
      .status        (status),
      .req_mode      (req_mode),
      .req_left_num  (req_left_num),
      .req_left_den  (req_left_den),
      .req_right_num (req_right_num),
      .req_right_den (req_right_den),
      .rsp_res_num   (rsp_res_num),
      .rsp_res_den   (rsp_res_den),
      .rsp_is_less   (rsp_is_less),
      .rsp_is_equal  (rsp_is_equal),
      .rsp_zero_den  (rsp_zero_den),
      .rsp_overflow  (rsp_overflow)
   );

   // A request is never taken while a response is still offered.
   a_no_take_while_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request taken while response pending");

   // Compare and fraction flags are exclusive in a response.
   a_flag_split: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_is_less || rsp_is_equal)) |-> !rsp_overflow && !rsp_zero_den)
      else $error("compare and fraction flags both set");

   // An accepted request leads to a busy unit in the next cycle.
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (req_stall && !rsp_valid))
      else $error("unit not busy after accepting a request");

endmodule
